>>> hw/rtl/bcomp_pkg.sv
// Package for the barometer compensation block.
// Holds status codes, register indexes, fixed coefficients and the pipeline item type.
// No dependencies.
package bcomp_pkg;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_CALIB = 2'd1,
    STATUS_DIV0  = 2'd2
  } status_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OSS     = 3'd3;

  localparam int DIV_T_W = 27;
  localparam int DIV_P_W = 32;

  localparam logic signed [31:0] T_ROUND   = 32'sd8;
  localparam logic signed [31:0] B6_OFFSET = 32'sd4000;
  localparam logic signed [31:0] B4_BIAS   = 32'sd32768;
  localparam logic signed [31:0] C_3038    = 32'sd3038;
  localparam logic signed [31:0] C_M7357   = -32'sd7357;
  localparam logic signed [31:0] C_3791    = 32'sd3791;
  localparam logic [31:0]        B7_SCALE  = 32'd50000;
  localparam logic signed [31:0] T_MAX     = 32'sd32767;
  localparam logic signed [31:0] T_MIN     = -32'sd32768;
  localparam logic signed [31:0] P_MAX     = 32'sd262143;

  typedef struct packed {
    logic [23:0]        up;
    logic signed [31:0] prod;
    logic signed [31:0] x1;
    logic signed [31:0] den;
    logic               q_neg;
    logic               dz_t;
    logic signed [31:0] x2;
    logic signed [31:0] b5;
    logic signed [31:0] t;
    logic signed [31:0] b6;
    logic signed [31:0] sq_p;
    logic signed [31:0] m_ac2;
    logic signed [31:0] m_ac3;
    logic signed [31:0] m_b2;
    logic signed [31:0] m_b1;
    logic signed [31:0] x3;
    logic signed [31:0] x3c;
    logic signed [31:0] s_b3;
    logic signed [31:0] u_b4;
    logic signed [31:0] b3;
    logic [31:0]        b4p;
    logic [31:0]        b4;
    logic               dz_p;
    logic [31:0]        diff;
    logic [31:0]        b7;
    logic               b7_hi;
    logic signed [31:0] p;
    logic signed [31:0] x1m;
    logic signed [31:0] x2m;
    logic signed [31:0] m3;
    logic signed [31:0] x2p;
    logic signed [31:0] sum;
    logic signed [31:0] p2;
  } pipe_t;

endpackage

>>> hw/rtl/bcomp_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Carries a tag and a valid bit alongside; all stages advance on en. No package use.
module bcomp_div #(
  parameter int NW = 32,
  parameter int DW = 32,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [NW-1:0] quotient,
  output logic [TW-1:0] tag_out
);

  logic [DW-1:0] rem_s [NW];
  logic [NW-1:0] wrk_s [NW];
  logic [DW-1:0] dvs_s [NW];
  logic [TW-1:0] tag_s [NW];
  logic          val_s [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] r_in;
    logic [NW-1:0] w_in;
    logic [DW-1:0] d_in;
    logic [TW-1:0] t_in;
    logic          v_in;
    logic [DW:0]   trial;
    logic [DW:0]   sub;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign w_in = dividend;
      assign d_in = divisor;
      assign t_in = tag_in;
      assign v_in = in_valid;
    end else begin : g_next
      assign r_in = rem_s[k-1];
      assign w_in = wrk_s[k-1];
      assign d_in = dvs_s[k-1];
      assign t_in = tag_s[k-1];
      assign v_in = val_s[k-1];
    end

    assign trial = {r_in, w_in[NW-1]};
    assign ge    = trial >= {1'b0, d_in};
    assign sub   = trial - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        val_s[k] <= 1'b0;
      end else if (en) begin
        val_s[k] <= v_in;
      end
      if (en) begin
        rem_s[k] <= ge ? sub[DW-1:0] : trial[DW-1:0];
        wrk_s[k] <= {w_in[NW-2:0], ge};
        dvs_s[k] <= d_in;
        tag_s[k] <= t_in;
      end
    end
  end

  assign out_valid = val_s[NW-1];
  assign quotient  = wrk_s[NW-1];
  assign tag_out   = tag_s[NW-1];

endmodule

>>> hw/rtl/barometer_compensation.sv
// Barometer pressure/temperature compensation, top level.
// Input channel in_valid/in_stall carries raw_temperature and raw_pressure_bytes;
// output channel out_valid/out_stall carries temperature_decidegrees (0.1 degC),
// pressure_pascal and status (ok, calibration invalid, division by zero).
// Calibration words and oversampling are written on cfg_valid/cfg_ready with
// cfg_index 0..3; other indexes are dropped. cfg_ready is always high. Write
// them only while no item is in flight.
// From accept to out_valid an item passes 2 front stages, a 27-stage
// temperature divider, 10 arithmetic stages, a 32-stage pressure divider,
// 5 stages of pressure correction and the output register.
// Throughput is one item per cycle while out_stall is low. When the receiver
// stalls with a result waiting, the pipeline keeps moving until its last stage
// holds an item, and only then raises in_stall; nothing is dropped or repeated.
// Reset clears the calibration registers to zero and empties the pipeline.
// Depends on bcomp_pkg and bcomp_div.
module barometer_compensation
  import bcomp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [15:0]          raw_temperature,
  input  logic [23:0]          raw_pressure_bytes,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   temperature_decidegrees,
  output logic [17:0]          pressure_pascal,
  output logic [1:0]           status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [63:0] calib_a;
  logic [63:0] calib_b;
  logic [31:0] calib_c;
  logic [1:0]  oss;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_a <= '0;
      calib_b <= '0;
      calib_c <= '0;
      oss     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CALIB_A: calib_a <= cfg_data;
        CFG_CALIB_B: calib_b <= cfg_data;
        CFG_CALIB_C: calib_c <= cfg_data[31:0];
        CFG_OSS:     oss     <= cfg_data[1:0];
        default:     ;
      endcase
    end
  end

  logic signed [31:0] ac1_w, ac2_w, ac3_w, b1_w, b2_w, mc_w, md_w;
  logic signed [31:0] ac5_w, ac6_w;
  logic [31:0]        ac4_u;
  logic               calib_bad;

  assign ac1_w = {{16{calib_a[63]}}, calib_a[63:48]};
  assign ac2_w = {{16{calib_a[47]}}, calib_a[47:32]};
  assign ac3_w = {{16{calib_a[31]}}, calib_a[31:16]};
  assign ac4_u = {16'b0, calib_a[15:0]};
  assign ac5_w = {16'b0, calib_b[63:48]};
  assign ac6_w = {16'b0, calib_b[47:32]};
  assign b1_w  = {{16{calib_b[31]}}, calib_b[31:16]};
  assign b2_w  = {{16{calib_b[15]}}, calib_b[15:0]};
  assign mc_w  = {{16{calib_c[31]}}, calib_c[31:16]};
  assign md_w  = {{16{calib_c[15]}}, calib_c[15:0]};

  assign calib_bad = (calib_a[63:48] == 16'h0000) || (calib_a[63:48] == 16'hFFFF) ||
                     (calib_b[63:48] == 16'h0000) || (calib_b[47:32] == 16'h0000);

  // flow control
  logic out_free;
  logic adv;
  logic v17;

  assign out_free = !out_valid || !out_stall;
  assign adv      = out_free || !v17;
  assign in_stall = !adv;

  // front stages
  pipe_t st_1, st_2;
  pipe_t st_1_next, st_2_next;
  logic  v1, v2;
  logic signed [31:0] s1_diff;
  logic signed [31:0] s2_x1;
  logic [3:0]         up_shift;

  assign s1_diff  = signed'({16'b0, raw_temperature}) - ac6_w;
  assign up_shift = 4'd8 - {2'b00, oss};
  assign s2_x1    = st_1.prod >>> 15;

  always_comb begin
    st_1_next      = '0;
    st_1_next.up   = raw_pressure_bytes >> up_shift;
    st_1_next.prod = s1_diff * ac5_w;
    st_2_next      = st_1;
    st_2_next.x1   = s2_x1;
    st_2_next.den  = s2_x1 + md_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
    end
    if (adv) begin
      st_1 <= st_1_next;
      st_2 <= st_2_next;
    end
  end

  // temperature divider
  logic signed [31:0] num_t;
  logic [31:0]        num_t_abs;
  logic [31:0]        den_t_abs;
  pipe_t              div_t_in;
  pipe_t              div_t_out;
  logic               div_t_v;
  logic [DIV_T_W-1:0] div_t_q;

  assign num_t     = mc_w <<< 11;
  assign num_t_abs = num_t[31] ? 32'(-num_t) : 32'(num_t);
  assign den_t_abs = st_2.den[31] ? 32'(-st_2.den) : 32'(st_2.den);

  always_comb begin
    div_t_in       = st_2;
    div_t_in.q_neg = num_t[31] ^ st_2.den[31];
    div_t_in.dz_t  = (st_2.den == 32'sd0);
  end

  bcomp_div #(
    .NW(DIV_T_W),
    .DW(32),
    .TW($bits(pipe_t))
  ) u_div_t (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v2),
    .dividend (num_t_abs[DIV_T_W-1:0]),
    .divisor  (den_t_abs),
    .tag_in   (div_t_in),
    .out_valid(div_t_v),
    .quotient (div_t_q),
    .tag_out  (div_t_out)
  );

  // middle stages
  pipe_t st_3, st_4, st_5, st_6, st_7, st_8, st_9, st_10, st_11, st_12;
  pipe_t st_3_next, st_4_next, st_5_next, st_6_next, st_7_next;
  pipe_t st_8_next, st_9_next, st_10_next, st_11_next, st_12_next;
  logic  v3, v4, v5, v6, v7, v8, v9, v10, v11, v12;
  logic signed [31:0] q_t_ext;
  logic signed [31:0] s7_sq;
  logic signed [31:0] s10_sh;
  logic [31:0]        b7_scale;

  assign q_t_ext  = signed'({{(32-DIV_T_W){1'b0}}, div_t_q});
  assign s7_sq    = st_6.sq_p >>> 12;
  assign s10_sh   = (st_9.s_b3 <<< oss) + 32'sd2;
  assign b7_scale = B7_SCALE >> oss;

  always_comb begin
    st_3_next       = div_t_out;
    st_3_next.x2    = div_t_out.q_neg ? -q_t_ext : q_t_ext;
    st_4_next       = st_3;
    st_4_next.b5    = st_3.x1 + st_3.x2;
    st_5_next       = st_4;
    st_5_next.t     = (st_4.b5 + T_ROUND) >>> 4;
    st_5_next.b6    = st_4.b5 - B6_OFFSET;
    st_6_next       = st_5;
    st_6_next.sq_p  = st_5.b6 * st_5.b6;
    st_6_next.m_ac2 = ac2_w * st_5.b6;
    st_6_next.m_ac3 = ac3_w * st_5.b6;
    st_7_next       = st_6;
    st_7_next.m_b2  = b2_w * s7_sq;
    st_7_next.m_b1  = b1_w * s7_sq;
    st_8_next       = st_7;
    st_8_next.x3    = (st_7.m_b2 >>> 11) + (st_7.m_ac2 >>> 11);
    st_8_next.x3c   = (st_7.m_ac3 >>> 13) + (st_7.m_b1 >>> 16) + 32'sd2;
    st_9_next       = st_8;
    st_9_next.s_b3  = (ac1_w <<< 2) + st_8.x3;
    st_9_next.u_b4  = (st_8.x3c >>> 2) + B4_BIAS;
    st_10_next      = st_9;
    st_10_next.b3   = s10_sh >>> 2;
    st_10_next.b4p  = ac4_u * unsigned'(st_9.u_b4);
    st_11_next      = st_10;
    st_11_next.b4   = st_10.b4p >> 15;
    st_11_next.dz_p = (st_10.b4p[31:15] == 17'd0);
    st_11_next.diff = {8'b0, st_10.up} - unsigned'(st_10.b3);
    st_12_next      = st_11;
    st_12_next.b7   = st_11.diff * b7_scale;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v3, v4, v5, v6, v7, v8, v9, v10, v11, v12} <= '0;
    end else if (adv) begin
      {v3, v4, v5, v6, v7, v8, v9, v10, v11, v12} <=
        {div_t_v, v3, v4, v5, v6, v7, v8, v9, v10, v11};
    end
    if (adv) begin
      st_3  <= st_3_next;
      st_4  <= st_4_next;
      st_5  <= st_5_next;
      st_6  <= st_6_next;
      st_7  <= st_7_next;
      st_8  <= st_8_next;
      st_9  <= st_9_next;
      st_10 <= st_10_next;
      st_11 <= st_11_next;
      st_12 <= st_12_next;
    end
  end

  // pressure divider
  pipe_t              div_p_in;
  pipe_t              div_p_out;
  logic               div_p_v;
  logic [DIV_P_W-1:0] div_p_q;
  logic [DIV_P_W-1:0] num_p;

  assign num_p = st_12.b7[31] ? st_12.b7 : {st_12.b7[30:0], 1'b0};

  always_comb begin
    div_p_in       = st_12;
    div_p_in.b7_hi = st_12.b7[31];
  end

  bcomp_div #(
    .NW(DIV_P_W),
    .DW(32),
    .TW($bits(pipe_t))
  ) u_div_p (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v12),
    .dividend (num_p),
    .divisor  (st_12.b4),
    .tag_in   (div_p_in),
    .out_valid(div_p_v),
    .quotient (div_p_q),
    .tag_out  (div_p_out)
  );

  // pressure correction
  pipe_t st_13, st_14, st_15, st_16, st_17;
  pipe_t st_13_next, st_14_next, st_15_next, st_16_next, st_17_next;
  logic  v13, v14, v15, v16;
  logic signed [31:0] s14_ps;

  assign s14_ps = st_13.p >>> 8;

  always_comb begin
    st_13_next     = div_p_out;
    st_13_next.p   = div_p_out.b7_hi ? signed'({div_p_q[30:0], 1'b0}) : signed'(div_p_q);
    st_14_next     = st_13;
    st_14_next.x1m = s14_ps * s14_ps;
    st_14_next.x2m = C_M7357 * st_13.p;
    st_15_next     = st_14;
    st_15_next.m3  = st_14.x1m * C_3038;
    st_15_next.x2p = st_14.x2m >>> 16;
    st_16_next     = st_15;
    st_16_next.sum = (st_15.m3 >>> 16) + st_15.x2p + C_3791;
    st_17_next     = st_16;
    st_17_next.p2  = st_16.p + (st_16.sum >>> 4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v13, v14, v15, v16, v17} <= '0;
    end else if (adv) begin
      {v13, v14, v15, v16, v17} <= {div_p_v, v13, v14, v15, v16};
    end
    if (adv) begin
      st_13 <= st_13_next;
      st_14 <= st_14_next;
      st_15 <= st_15_next;
      st_16 <= st_16_next;
      st_17 <= st_17_next;
    end
  end

  // saturation and output register
  logic signed [15:0] t_sat;
  logic [17:0]        p_sat;

  always_comb begin
    if (st_17.t > T_MAX) begin
      t_sat = 16'sh7FFF;
    end else if (st_17.t < T_MIN) begin
      t_sat = 16'sh8000;
    end else begin
      t_sat = st_17.t[15:0];
    end
    if (st_17.p2 < 32'sd0) begin
      p_sat = '0;
    end else if (st_17.p2 > P_MAX) begin
      p_sat = '1;
    end else begin
      p_sat = st_17.p2[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= v17;
    end
    if (out_free) begin
      if (calib_bad) begin
        temperature_decidegrees <= '0;
        pressure_pascal         <= '0;
        status                  <= STATUS_CALIB;
      end else if (st_17.dz_t || st_17.dz_p) begin
        temperature_decidegrees <= '0;
        pressure_pascal         <= '0;
        status                  <= STATUS_DIV0;
      end else begin
        temperature_decidegrees <= t_sat;
        pressure_pascal         <= p_sat;
        status                  <= STATUS_OK;
      end
    end
  end

endmodule
